@@ rtl/core/indexed_list_insert_remove_search_defines.svh @@
// Assertion macros shared by the list RTL.
`ifndef INDEXED_LIST_INSERT_REMOVE_SEARCH_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_SEARCH_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ILIST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ILIST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ilist_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ilist_pkg;

   // Item field widths
   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int FPOS_W  = 6;
   localparam int LEN_W   = 7;

   // Operation codes; 6 and 7 are unused
   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_READ   = 3'd4,
      OP_CLEAR  = 3'd5
   } ilist_op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_PUT
   } ilist_state_type;

endpackage

`default_nettype wire

@@ rtl/core/ilist_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ilist_ram
   import ilist_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/indexed_list_insert_remove_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of signed 32-bit entries, up to CAPACITY of them.
// Input: drive req_operation, req_position and req_entry_value with start high;
// the item is taken at a rising edge where start is high and busy is low.
// Output: one result per item, on the rsp_ ports for exactly one cycle with
// rsp_valid high; the receiver cannot stall, so results must be taken at once.
// Entries live in a single-port-write, registered-read RAM, and one shared
// read/compare step walks it under a small sequencer, through a fetch state
// and an exec state per entry. Append, clear, unused codes, failed append,
// insert or remove, read or search of an empty list and one-step insert or
// remove finish straight from idle. A read of a non-empty list passes once
// through fetch and exec. Insert at p shifts entries up one slot from the
// tail down to p, then puts the value at p; remove at p shifts entries down
// from p+1 to the end; search compares from index 0 up to the hit index k
// (len-1 on a miss). busy is high while the sequencer is out of idle; a new
// item may be accepted in the same cycle its predecessor's result is shown.
// Reset empties the list (length 0); entry contents are not cleared and
// are only read after being written.
module indexed_list_insert_remove_search
   import ilist_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OP_W-1:0]          req_operation,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_entry_value,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic                          rsp_found,
   output logic [FPOS_W-1:0]             rsp_found_position,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic [LEN_W-1:0]              rsp_length
);

   `include "indexed_list_insert_remove_search_defines.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > POS_W) ? LW : POS_W;
   localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

   ilist_state_type   state_ff, state_in;
   ilist_op_type      op_ff, op_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [FPOS_W-1:0] rsp_fpos_ff, rsp_fpos_in;
   logic [DATA_W-1:0] rsp_rval_ff, rsp_rval_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic              accept;
   logic [CW-1:0]     pos_ext;
   logic [CW-1:0]     len_ext;

   ilist_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign pos_ext = CW'(req_position);
   assign len_ext = CW'(len_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_fpos_ff  <= rsp_fpos_in;
      rsp_rval_ff  <= rsp_rval_in;
   end

   // Sequencer: next state, RAM port control and results
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_found_in = rsp_found_ff;
      rsp_fpos_in  = rsp_fpos_ff;
      rsp_rval_in  = rsp_rval_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in        = ilist_op_type'(req_operation);
               val_in       = req_entry_value;
               pos_in       = AW'(req_position);
               rsp_ok_in    = 1'b0;
               rsp_found_in = 1'b0;
               rsp_fpos_in  = '0;
               rsp_rval_in  = '0;
               unique case (ilist_op_type'(req_operation))
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (len_ff < CAP_LEN) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(len_ff);
                        ram_wr_data = req_entry_value;
                        len_in      = len_ff + 1'b1;
                        rsp_ok_in   = 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (len_ff < CAP_LEN && pos_ext <= len_ext) begin
                        if (pos_ext == len_ext) begin
                           // insert at the tail is an append
                           ram_wr_en    = 1'b1;
                           ram_wr_addr  = AW'(len_ff);
                           ram_wr_data  = req_entry_value;
                           len_in       = len_ff + 1'b1;
                           rsp_ok_in    = 1'b1;
                           rsp_valid_in = 1'b1;
                        end else begin
                           idx_in   = AW'(len_ff);
                           state_in = ST_FETCH;
                        end
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_ext < len_ext) begin
                        if (pos_ext + 1'b1 == len_ext) begin
                           // last entry: nothing to shift
                           len_in       = len_ff - 1'b1;
                           rsp_ok_in    = 1'b1;
                           rsp_valid_in = 1'b1;
                        end else begin
                           idx_in   = AW'(req_position);
                           state_in = ST_FETCH;
                        end
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     rsp_ok_in = 1'b1;
                     if (len_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_READ: begin
                     if (pos_ext < len_ext) begin
                        rsp_ok_in = 1'b1;
                        idx_in    = AW'(req_position);
                        state_in  = ST_FETCH;
                     end else if (len_ff != '0) begin
                        // bad position reads entry 0
                        idx_in   = '0;
                        state_in = ST_FETCH;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     len_in       = '0;
                     rsp_ok_in    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // Present the neighbor or current address to the RAM
         ST_FETCH: begin
            unique case (op_ff)
               OP_INSERT: ram_rd_addr = idx_ff - 1'b1;
               OP_REMOVE: ram_rd_addr = idx_ff + 1'b1;
               default:   ram_rd_addr = idx_ff;
            endcase
            state_in = ST_EXEC;
         end

         // Use the fetched entry: shift it, compare it or return it
         ST_EXEC: begin
            unique case (op_ff)
               OP_INSERT: begin
                  ram_wr_en = 1'b1;
                  idx_in    = idx_ff - 1'b1;
                  state_in  = (idx_ff - 1'b1 == pos_ff) ? ST_PUT : ST_FETCH;
               end
               OP_REMOVE: begin
                  ram_wr_en = 1'b1;
                  idx_in    = idx_ff + 1'b1;
                  if (LW'(idx_ff) + LW'(2) == len_ff) begin
                     len_in       = len_ff - 1'b1;
                     rsp_ok_in    = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
               OP_SEARCH: begin
                  idx_in = idx_ff + 1'b1;
                  if (ram_rd_data == val_ff) begin
                     rsp_found_in = 1'b1;
                     rsp_fpos_in  = FPOS_W'(idx_ff);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else if (LW'(idx_ff) + LW'(1) == len_ff) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
               default: begin
                  rsp_rval_in  = ram_rd_data;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end

         // Drop the new value into the opened slot
         ST_PUT: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = pos_ff;
            ram_wr_data  = val_ff;
            len_in       = len_ff + 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_read_value     = rsp_rval_ff;
   assign rsp_length         = LEN_W'(len_ff);

   `ILIST_ASSERT_NOW(a_len_in_range, clock, reset, 1'b1, len_ff <= CAP_LEN,
      "list length exceeds capacity")
   `ILIST_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE,
      "result shown while sequencer busy")
   `ILIST_ASSERT_NEXT(a_clear_empties, clock, reset,
      accept && req_operation == OP_CLEAR,
      rsp_valid_ff && rsp_ok_ff && len_ff == '0, "clear did not empty the list")
   `ILIST_ASSERT_NEXT(a_append_one_cycle, clock, reset,
      accept && req_operation == OP_APPEND && len_ff < CAP_LEN,
      rsp_valid_ff && rsp_ok_ff && len_ff == $past(len_ff) + 1'b1,
      "append did not complete in one cycle")

endmodule

`default_nettype wire
